// ===== rtl/core/ldt_pkg.sv =====
package ldt_pkg;

    localparam int TABLE_ENTRIES_DEF = 8192;
    localparam int DESC_W = 64;

    localparam logic [2:0] FUNC_READ      = 3'd0;
    localparam logic [2:0] FUNC_WRITE_OLD = 3'd1;
    localparam logic [2:0] FUNC_WRITE_NEW = 3'd2;
    localparam logic [2:0] FUNC_TRANSLATE = 3'd3;

    localparam logic [2:0] STATUS_OK     = 3'd0;
    localparam logic [2:0] STATUS_INVAL  = 3'd1;
    localparam logic [2:0] STATUS_NOSYS  = 3'd2;
    localparam logic [2:0] STATUS_BADSEL = 3'd3;
    localparam logic [2:0] STATUS_LIMIT  = 3'd4;

    localparam logic [16:0] WRITE_BYTES   = 17'd16;
    localparam logic [16:0] MAX_BUF_BYTES = 17'd65536;
    localparam logic [1:0]  CONTENTS_CODE = 2'd3;
    localparam logic [2:0]  SEL_RPL_TI    = 3'd7;

    typedef struct packed {
        logic [2:0]  func;
        logic [12:0] entry_index;
        logic [15:0] selector;
        logic [31:0] address;
        logic [19:0] limit;
        logic [1:0]  contents;
        logic        write_locked;
        logic        op_size_32;
        logic        page_granular;
        logic        marked_absent;
        logic        useable;
        logic [16:0] byte_count;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] word_low;
        logic [31:0] word_high;
        logic [31:0] linear_address;
        logic [16:0] bytes_copied;
    } rsp_t;

    function automatic logic [DESC_W-1:0] pack_descriptor(req_t r, logic old_mode);
        logic [31:0] lo;
        logic [31:0] hi;
        logic        clear_entry;
        clear_entry = (r.address == 32'd0) && (r.limit == 20'd0) &&
                      (old_mode || ((r.contents == 2'd0) && r.write_locked &&
                                    !r.op_size_32 && !r.page_granular &&
                                    r.marked_absent && !r.useable));
        lo = {r.address[15:0], r.limit[15:0]};
        hi = {r.address[31:24], r.page_granular, r.op_size_32, 1'b0,
              r.useable & !old_mode, r.limit[19:16], !r.marked_absent, 3'b111,
              r.contents, !r.write_locked, 1'b0, r.address[23:16]};
        if (clear_entry)
        begin
            return '0;
        end
        return {hi, lo};
    endfunction

endpackage

// ===== rtl/core/ldt_ram.sv =====
module ldt_ram #(
    parameter int WIDTH = ldt_pkg::DESC_W,
    parameter int DEPTH = ldt_pkg::TABLE_ENTRIES_DEF,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/ldt_descriptor_table_unit.sv =====
// Local descriptor table unit with one request channel and one response channel.
// A request word carries a function code: read an entry, write an entry in old
// or new mode, or translate a selector and offset into a linear address.
// Every accepted request produces exactly one response word, in order.
// Both channels use valid and stall; a word moves when valid is high and stall
// is low. The descriptor memory is read at the edge that accepts a request and
// the result is registered into the response register at the next edge, which
// makes the response word valid. One request is in progress at a time, so the
// unit takes no new request while a lookup is pending. A request is taken only
// once the response register is free or its word is being taken in the same
// cycle.
// After reset the unit zeroes the descriptor memory, one entry per cycle, and
// holds stall high on the request channel until every entry is cleared.
// Reset also marks the table absent. While the receiver stalls, the response
// word is held and no new request is taken once the unit is waiting to deliver.
module ldt_descriptor_table_unit #(
    parameter int TABLE_ENTRIES = ldt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  ldt_pkg::req_t req_word,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ldt_pkg::rsp_t rsp_word
);

    localparam int ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [13:0] ENTRY_LIMIT = 14'(TABLE_ENTRIES);
    localparam logic [17:0] TABLE_BYTES = 18'(TABLE_ENTRIES * 8);
    localparam logic [ADDR_W-1:0] LAST_ENTRY = ADDR_W'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    state_t        state_reg;
    state_t        state_next;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [ADDR_W-1:0] clr_cnt_next;
    logic          present_reg;
    logic          present_next;
    ldt_pkg::req_t req_reg;
    ldt_pkg::req_t req_next;
    logic          rsp_valid_reg;
    logic          rsp_valid_next;
    ldt_pkg::rsp_t rsp_reg;
    ldt_pkg::rsp_t rsp_next;

    logic          accept;
    logic          mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ldt_pkg::DESC_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [ldt_pkg::DESC_W-1:0] mem_rdata;

    logic          old_mode;
    logic          write_ok;
    logic [16:0]   bc_sat;
    logic [12:0]   slot;
    logic [31:0]   seg_base;
    logic [19:0]   seg_lim;
    logic [31:0]   eff_lim;
    ldt_pkg::rsp_t result;

    assign accept = req_valid && !req_stall;
    assign req_stall = !((state_reg == ST_IDLE) && (!rsp_valid_reg || !rsp_stall));
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word = rsp_reg;

    assign mem_raddr = (req_word.func == ldt_pkg::FUNC_TRANSLATE) ?
                       req_word.selector[ADDR_W+2:3] : req_word.entry_index[ADDR_W-1:0];

    ldt_ram #(
        .WIDTH(ldt_pkg::DESC_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_desc_ram (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (accept),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    always_comb
    begin
        old_mode = (req_reg.func == ldt_pkg::FUNC_WRITE_OLD);
        bc_sat = (req_reg.byte_count > ldt_pkg::MAX_BUF_BYTES) ?
                 ldt_pkg::MAX_BUF_BYTES : req_reg.byte_count;
        slot = req_reg.selector[15:3];
        write_ok = (req_reg.byte_count == ldt_pkg::WRITE_BYTES) &&
                   ({1'b0, req_reg.entry_index} < ENTRY_LIMIT) &&
                   !((req_reg.contents == ldt_pkg::CONTENTS_CODE) &&
                     (old_mode || !req_reg.marked_absent));
        seg_base = '0;
        seg_lim = '0;
        eff_lim = '0;
        if (present_reg)
        begin
            seg_base = {mem_rdata[63:56], mem_rdata[39:32], mem_rdata[31:16]};
            seg_lim = {mem_rdata[51:48], mem_rdata[15:0]};
            eff_lim = mem_rdata[55] ? {seg_lim, 12'hfff} : {12'd0, seg_lim};
        end
        result = '0;
        case (req_reg.func)
            ldt_pkg::FUNC_READ:
            begin
                if ({1'b0, req_reg.entry_index} >= ENTRY_LIMIT)
                begin
                    result.status = ldt_pkg::STATUS_INVAL;
                end
                else if (present_reg)
                begin
                    result.word_low = mem_rdata[31:0];
                    result.word_high = mem_rdata[63:32];
                    result.bytes_copied = ({1'b0, bc_sat} < TABLE_BYTES) ?
                                          bc_sat : TABLE_BYTES[16:0];
                end
            end
            ldt_pkg::FUNC_WRITE_OLD, ldt_pkg::FUNC_WRITE_NEW:
            begin
                if (!write_ok)
                begin
                    result.status = ldt_pkg::STATUS_INVAL;
                end
            end
            ldt_pkg::FUNC_TRANSLATE:
            begin
                if ((req_reg.selector[2:0] != ldt_pkg::SEL_RPL_TI) ||
                    ({1'b0, slot} >= ENTRY_LIMIT))
                begin
                    result.status = ldt_pkg::STATUS_BADSEL;
                end
                else
                begin
                    result.linear_address = seg_base + req_reg.address;
                    if (req_reg.address > eff_lim)
                    begin
                        result.status = ldt_pkg::STATUS_LIMIT;
                    end
                end
            end
            default:
            begin
                result.status = ldt_pkg::STATUS_NOSYS;
            end
        endcase
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_waddr = clr_cnt_reg;
        mem_wdata = '0;
        if (state_reg == ST_CLEAR)
        begin
            mem_we = 1'b1;
        end
        else if ((state_reg == ST_LOOKUP) && write_ok &&
                 ((req_reg.func == ldt_pkg::FUNC_WRITE_OLD) ||
                  (req_reg.func == ldt_pkg::FUNC_WRITE_NEW)))
        begin
            mem_we = 1'b1;
            mem_waddr = req_reg.entry_index[ADDR_W-1:0];
            mem_wdata = ldt_pkg::pack_descriptor(req_reg, old_mode);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_cnt_next = clr_cnt_reg;
        present_next = present_reg;
        req_next = req_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next = rsp_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ENTRY)
                begin
                    clr_cnt_next = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next = req_word;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (mem_we)
                begin
                    present_next = 1'b1;
                end
                rsp_valid_next = 1'b1;
                rsp_next = result;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_cnt_reg <= '0;
            present_reg <= 1'b0;
            req_reg <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            present_reg <= present_next;
            req_reg <= req_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg <= rsp_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 rsp_valid)
        else $error("Accepted request did not produce a response two cycles later.");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !rsp_valid)
        else $error("Request taken while the response register was still occupied.");

    assert property (@(posedge clk) disable iff (!rst_n)
        present_reg |-> (state_reg != ST_CLEAR))
        else $error("Table marked present during the clearing pass.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_word.status != ldt_pkg::STATUS_OK) &&
         (rsp_word.status != ldt_pkg::STATUS_LIMIT)) |->
        ((rsp_word.word_low == 32'd0) && (rsp_word.word_high == 32'd0) &&
         (rsp_word.linear_address == 32'd0) && (rsp_word.bytes_copied == 17'd0)))
        else $error("Error response carries nonzero data fields.");

endmodule
